// ===== rtl/rmfw_pkg.sv =====
// Shared types, constants and codes for the recursive mutex with a FIFO wait queue.
`timescale 1ns / 1ps

package rmfw_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int THREAD_COUNT_DEF = 16;
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int COUNT_BITS_DEF   = 8;

	// Fixed field widths of the request and response words
	localparam int TID_W    = 4;
	localparam int STATUS_W = 4;
	localparam int HOLD_W   = 8;

	// Request operation codes
	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Response status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED         = 4'd0,
		ST_REGRANTED       = 4'd1,
		ST_BLOCKED         = 4'd2,
		ST_STILL_HELD      = 4'd3,
		ST_FREED           = 4'd4,
		ST_ALREADY_WAITING = 4'd5,
		ST_NOT_HOLDER      = 4'd6,
		ST_QUEUE_FULL      = 4'd7,
		ST_OVERFLOW        = 4'd8
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_stall;
	} dp_status_t;

endpackage

// ===== rtl/rmfw_req_if.sv =====
// Request channel: valid/ready handshake carrying one lock operation word.
`timescale 1ns / 1ps

interface rmfw_req_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [rmfw_pkg::TID_W-1:0] thread_id;

	modport source (output valid, output cmd, output thread_id, input ready);
	modport sink   (input valid, input cmd, input thread_id, output ready);
endinterface

// ===== rtl/rmfw_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one lock result word.
`timescale 1ns / 1ps

interface rmfw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rmfw_pkg::STATUS_W-1:0] status;
	logic                         wake_valid;
	logic [rmfw_pkg::TID_W-1:0]    wake_thread;
	logic [rmfw_pkg::HOLD_W-1:0]   hold_count;

	modport source (output valid, output status, output wake_valid, output wake_thread,
		output hold_count, input ready);
	modport sink   (input valid, input status, input wake_valid, input wake_thread,
		input hold_count, output ready);
endinterface

// ===== rtl/rmfw_ctrl.sv =====
// Controller state machine: captures a request word, then fires the update step.
`timescale 1ns / 1ps

module rmfw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rmfw_pkg::dp_status_t dp_status,
	output rmfw_pkg::ctl_cmd_t   ctl_cmd
);

	rmfw_pkg::state_t state_q;
	rmfw_pkg::state_t state_n;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmfw_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Advance: take a word, then execute once the output register can load
	always_comb begin
		state_n = state_q;
		case (state_q)
			rmfw_pkg::S_IDLE: begin
				if (in_valid) begin
					state_n = rmfw_pkg::S_EXEC;
				end
			end
			rmfw_pkg::S_EXEC: begin
				if (!dp_status.out_stall) begin
					state_n = rmfw_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = rmfw_pkg::S_IDLE;
			end
		endcase
	end

	// Drive handshake and datapath commands
	always_comb begin
		in_ready        = 1'b0;
		ctl_cmd.capture = 1'b0;
		ctl_cmd.exec    = 1'b0;
		case (state_q)
			rmfw_pkg::S_IDLE: begin
				in_ready        = 1'b1;
				ctl_cmd.capture = in_valid;
			end
			rmfw_pkg::S_EXEC: begin
				ctl_cmd.exec = !dp_status.out_stall;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/rmfw_dp.sv =====
// Datapath: holder registers, waiter queue memory, waiting map and output register.
`timescale 1ns / 1ps

module rmfw_dp #(
	parameter int THREAD_COUNT = rmfw_pkg::THREAD_COUNT_DEF,
	parameter int QUEUE_DEPTH  = rmfw_pkg::QUEUE_DEPTH_DEF,
	parameter int COUNT_BITS   = rmfw_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rmfw_pkg::ctl_cmd_t            ctl_cmd,
	output rmfw_pkg::dp_status_t          dp_status,
	input  logic                          in_cmd,
	input  logic [rmfw_pkg::TID_W-1:0]    in_thread_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rmfw_pkg::STATUS_W-1:0] out_status,
	output logic                          out_wake_valid,
	output logic [rmfw_pkg::TID_W-1:0]    out_wake_thread,
	output logic [rmfw_pkg::HOLD_W-1:0]   out_hold_count
);

	localparam int TID_W   = rmfw_pkg::TID_W;
	localparam int HOLD_W  = rmfw_pkg::HOLD_W;
	localparam int TC_W    = $clog2(THREAD_COUNT + 1);
	localparam int CMP_W   = (TC_W > TID_W) ? TC_W : TID_W;
	localparam int MAP_IW  = $clog2(THREAD_COUNT);
	localparam int QIW     = $clog2(QUEUE_DEPTH);
	localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int EXT_W   = COUNT_BITS + HOLD_W;

	// Captured request word
	logic             cmd_q;
	logic [TID_W-1:0] tid_q;

	// Lock state
	logic                    holder_valid_q;
	logic [TID_W-1:0]        holder_id_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [THREAD_COUNT-1:0] waiting_q;
	logic [QIW-1:0]          head_q;
	logic [QIW-1:0]          tail_q;
	logic [FILL_W-1:0]       fill_q;

	// Waiter queue memory and its registered head read
	logic [TID_W-1:0] queue_mem [QUEUE_DEPTH];
	logic [TID_W-1:0] head_rd_q;

	// Output register
	logic                   out_valid_q;
	rmfw_pkg::status_t      status_q;
	logic                   wake_q;
	logic [TID_W-1:0]       wake_tid_q;
	logic [HOLD_W-1:0]      hold_q;

	// Decode and next values
	logic [CMP_W-1:0]      tid_ext;
	logic [CMP_W-1:0]      rd_ext;
	logic [MAP_IW-1:0]     tid_idx;
	logic [MAP_IW-1:0]     rd_idx;
	logic                  tid_ok;
	logic                  is_holder;
	logic                  q_full;
	rmfw_pkg::status_t     st_n;
	logic                  grant;
	logic                  regrant;
	logic                  dec;
	logic                  free;
	logic                  push;
	logic                  pop;
	logic [COUNT_BITS-1:0] count_n;
	logic [EXT_W-1:0]      count_ext;
	logic                  exec;

	assign exec    = ctl_cmd.exec;
	assign tid_ext = CMP_W'(tid_q);
	assign rd_ext  = CMP_W'(head_rd_q);
	assign tid_idx = tid_ext[MAP_IW-1:0];
	assign rd_idx  = rd_ext[MAP_IW-1:0];
	assign tid_ok  = tid_ext < CMP_W'(THREAD_COUNT);
	assign is_holder = holder_valid_q && (holder_id_q == tid_q);
	assign q_full    = fill_q >= FILL_W'(QUEUE_DEPTH);

	// Decide the outcome of the captured request
	always_comb begin
		st_n    = rmfw_pkg::ST_NOT_HOLDER;
		grant   = 1'b0;
		regrant = 1'b0;
		dec     = 1'b0;
		free    = 1'b0;
		push    = 1'b0;
		pop     = 1'b0;
		if (tid_ok) begin
			if (cmd_q == rmfw_pkg::CMD_ACQUIRE) begin
				if (is_holder) begin
					if (&count_q) begin
						st_n = rmfw_pkg::ST_OVERFLOW;
					end else begin
						st_n    = rmfw_pkg::ST_REGRANTED;
						regrant = 1'b1;
					end
				end else if (waiting_q[tid_idx]) begin
					st_n = rmfw_pkg::ST_ALREADY_WAITING;
				end else if (!holder_valid_q) begin
					st_n  = rmfw_pkg::ST_GRANTED;
					grant = 1'b1;
				end else if (q_full) begin
					st_n = rmfw_pkg::ST_QUEUE_FULL;
				end else begin
					st_n = rmfw_pkg::ST_BLOCKED;
					push = 1'b1;
				end
			end else begin
				if (!is_holder) begin
					st_n = rmfw_pkg::ST_NOT_HOLDER;
				end else if (count_q > COUNT_BITS'(1)) begin
					st_n = rmfw_pkg::ST_STILL_HELD;
					dec  = 1'b1;
				end else begin
					st_n = rmfw_pkg::ST_FREED;
					free = 1'b1;
					pop  = (fill_q != '0);
				end
			end
		end
	end

	// Next repeat count
	always_comb begin
		count_n = count_q;
		if (grant) begin
			count_n = COUNT_BITS'(1);
		end else if (regrant) begin
			count_n = count_q + COUNT_BITS'(1);
		end else if (dec) begin
			count_n = count_q - COUNT_BITS'(1);
		end else if (free) begin
			count_n = '0;
		end
	end

	assign count_ext = EXT_W'(count_n);

	// Capture the request word
	always_ff @(posedge clk) begin
		if (ctl_cmd.capture) begin
			cmd_q <= in_cmd;
			tid_q <= in_thread_id;
		end
	end

	// Update holder, count, queue pointers and waiting map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holder_valid_q <= 1'b0;
			holder_id_q    <= '0;
			count_q        <= '0;
			waiting_q      <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			fill_q         <= '0;
		end else if (exec) begin
			count_q <= count_n;
			if (grant) begin
				holder_valid_q <= 1'b1;
				holder_id_q    <= tid_q;
			end else if (free) begin
				holder_valid_q <= 1'b0;
				holder_id_q    <= '0;
			end
			if (push) begin
				waiting_q[tid_idx] <= 1'b1;
				tail_q <= (tail_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QIW'(1);
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop) begin
				waiting_q[rd_idx] <= 1'b0;
				head_q <= (head_q == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QIW'(1);
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	// Write the tail, read the head every cycle
	always_ff @(posedge clk) begin
		if (exec && push) begin
			queue_mem[tail_q] <= tid_q;
		end
		head_rd_q <= queue_mem[head_q];
	end

	// Hold the response word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q   <= st_n;
			wake_q     <= pop;
			wake_tid_q <= pop ? head_rd_q : '0;
			hold_q     <= count_ext[HOLD_W-1:0];
		end
	end

	assign dp_status.out_stall = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign out_status      = status_q;
	assign out_wake_valid  = wake_q;
	assign out_wake_thread = wake_tid_q;
	assign out_hold_count  = hold_q;

`ifndef SYNTHESIS
	// Queue fill never passes the depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("waiter queue fill beyond depth");

	// Every queued thread has exactly one waiting bit
	a_map_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(waiting_q) == int'(fill_q))
		else $error("waiting map out of step with queue fill");

	// A held lock has a nonzero count, a free lock a zero count
	a_count_holder: assert property (@(posedge clk) disable iff (!arst_n)
		holder_valid_q == (count_q != '0))
		else $error("repeat count disagrees with holder state");

	// A wake only comes with a freeing release
	a_wake_freed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && wake_q) |-> (status_q == rmfw_pkg::ST_FREED))
		else $error("wake reported without lock free");
`endif

endmodule

// ===== rtl/recursive_mutex_fifo_waiters.sv =====
// Top level of the recursive mutex with a FIFO wait queue.
`timescale 1ns / 1ps

// Recursive mutex with a FIFO of waiting threads. Each request word (acquire or
// release by a thread id) gives exactly one response word with status, an optional
// woken thread and the holder's repeat count. A request is first captured, then the
// holder registers, the queue pointers and the waiting map are updated in a single
// step; the update waits while the output register still holds a word that has not
// been taken, and a new request is taken while that word waits. Waiting thread ids
// live in a QUEUE_DEPTH-entry memory whose head entry is read into a register every
// cycle, so a freeing release takes its waiter straight from that register. A woken
// thread must issue acquire again to take the lock.
module recursive_mutex_fifo_waiters #(
	parameter int THREAD_COUNT = rmfw_pkg::THREAD_COUNT_DEF,
	parameter int QUEUE_DEPTH  = rmfw_pkg::QUEUE_DEPTH_DEF,
	parameter int COUNT_BITS   = rmfw_pkg::COUNT_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	rmfw_req_if.sink     req,
	rmfw_rsp_if.source   rsp
);

	rmfw_pkg::ctl_cmd_t   ctl_cmd;
	rmfw_pkg::dp_status_t dp_status;

	rmfw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.dp_status (dp_status),
		.ctl_cmd   (ctl_cmd)
	);

	rmfw_dp #(
		.THREAD_COUNT (THREAD_COUNT),
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.COUNT_BITS   (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl_cmd         (ctl_cmd),
		.dp_status       (dp_status),
		.in_cmd          (req.cmd),
		.in_thread_id    (req.thread_id),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_wake_valid  (rsp.wake_valid),
		.out_wake_thread (rsp.wake_thread),
		.out_hold_count  (rsp.hold_count)
	);

endmodule

// ===== tb/recursive_mutex_fifo_waiters_test.sv =====
// Self-checking testbench for the recursive mutex with a FIFO wait queue.
`timescale 1ns / 1ps

module recursive_mutex_fifo_waiters_test;

	localparam int THREADS    = rmfw_pkg::THREAD_COUNT_DEF;
	localparam int WAIT_SLOTS = rmfw_pkg::QUEUE_DEPTH_DEF;
	localparam int TID_W      = rmfw_pkg::TID_W;
	localparam int HOLD_W     = rmfw_pkg::HOLD_W;
	localparam int COUNT_W    = rmfw_pkg::COUNT_BITS_DEF;
	localparam int RANDOM_OPS = 130;
	localparam int PAUSE_AT   = 40;
	localparam int STEADY_LO  = 585;
	localparam int STEADY_HI  = 640;
	localparam int HOLD_AT    = 590;
	localparam int HOLD_LEN   = 150;
	localparam int SCRIPT_LEN = 18;

	// One response word as the lock reports it
	typedef struct {
		rmfw_pkg::status_t    status;
		logic                 wake_valid;
		logic [TID_W-1:0]     wake_thread;
		logic [HOLD_W-1:0]    hold_count;
	} lock_word_t;

	// One row of the directed script; a row may repeat its operation
	typedef struct {
		logic             op;
		logic [TID_W-1:0] tid;
		int               reps;
		bit               typed;
		lock_word_t       want;
	} script_row_t;

	logic clk;
	logic arst_n;

	rmfw_req_if req_ch ();
	rmfw_rsp_if rsp_ch ();

	recursive_mutex_fifo_waiters u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the lock
	logic                    lock_held;
	logic [TID_W-1:0]        owner_tid;
	logic [COUNT_W-1:0]      owner_depth;
	logic [TID_W-1:0]        wait_fifo[$];
	logic [THREADS-1:0]      waiting_bits;
	int                      retry_tid;

	lock_word_t  expected_words[$];
	script_row_t script [SCRIPT_LEN];
	int          word_count;
	int          errors;
	bit          hold_done;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one operation to the shadow lock and return the word it reports
	function automatic lock_word_t apply_lock_op(input logic op, input logic [TID_W-1:0] tid);
		lock_word_t w;
		w.status      = rmfw_pkg::ST_NOT_HOLDER;
		w.wake_valid  = 1'b0;
		w.wake_thread = '0;
		if (int'(tid) >= THREADS) begin
			w.status = rmfw_pkg::ST_NOT_HOLDER;
		end else if (op == rmfw_pkg::CMD_ACQUIRE) begin
			if (lock_held && owner_tid == tid) begin
				if (owner_depth == '1) begin
					w.status = rmfw_pkg::ST_OVERFLOW;
				end else begin
					owner_depth = owner_depth + COUNT_W'(1);
					w.status = rmfw_pkg::ST_REGRANTED;
				end
			end else if (waiting_bits[tid]) begin
				w.status = rmfw_pkg::ST_ALREADY_WAITING;
			end else if (!lock_held) begin
				lock_held   = 1'b1;
				owner_tid   = tid;
				owner_depth = COUNT_W'(1);
				w.status    = rmfw_pkg::ST_GRANTED;
			end else if (wait_fifo.size() >= WAIT_SLOTS) begin
				w.status = rmfw_pkg::ST_QUEUE_FULL;
			end else begin
				wait_fifo.push_back(tid);
				waiting_bits[tid] = 1'b1;
				w.status = rmfw_pkg::ST_BLOCKED;
			end
		end else begin
			if (!lock_held || owner_tid != tid) begin
				w.status = rmfw_pkg::ST_NOT_HOLDER;
			end else if (owner_depth > COUNT_W'(1)) begin
				owner_depth = owner_depth - COUNT_W'(1);
				w.status = rmfw_pkg::ST_STILL_HELD;
			end else begin
				lock_held   = 1'b0;
				owner_tid   = '0;
				owner_depth = '0;
				w.status    = rmfw_pkg::ST_FREED;
				// pop the oldest waiter; it has to retry on its own
				if (wait_fifo.size() != 0) begin
					w.wake_thread = wait_fifo.pop_front();
					w.wake_valid  = 1'b1;
					waiting_bits[w.wake_thread] = 1'b0;
					retry_tid = int'(w.wake_thread);
				end
			end
		end
		w.hold_count = owner_depth[HOLD_W-1:0];
		return w;
	endfunction

	// Mostly short gaps, some longer, none inside the steady window
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (word_count >= STEADY_LO && word_count < STEADY_HI)
			return 0;
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	// Offer one request word and hold it until accepted
	task automatic send_word(input logic op, input logic [TID_W-1:0] tid, input bit typed,
		input lock_word_t want);
		lock_word_t w;
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= op;
		req_ch.thread_id <= tid;
		do @(posedge clk); while (!req_ch.ready);
		w = apply_lock_op(op, tid);
		expected_words.push_back(typed ? want : w);
		word_count++;
	endtask

	// Idle the request side, or drain every outstanding response
	task automatic idle_sender(input bit drain);
		int gap;
		gap = pick_gap();
		if (drain) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while (expected_words.size() != 0);
		end else if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Request side: directed script, then random traffic
	initial begin
		lock_word_t       none;
		logic             op;
		logic [TID_W-1:0] tid;
		int               roll;

		none = '{rmfw_pkg::ST_GRANTED, 1'b0, '0, '0};
		script = '{
			'{rmfw_pkg::CMD_RELEASE, 4'd0,   1,   1'b1,
				'{rmfw_pkg::ST_NOT_HOLDER, 1'b0, 4'd0, 8'd0}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd0,   1,   1'b1,
				'{rmfw_pkg::ST_GRANTED, 1'b0, 4'd0, 8'd1}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd0,   1,   1'b1,
				'{rmfw_pkg::ST_REGRANTED, 1'b0, 4'd0, 8'd2}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd0,   253, 1'b0,
				'{rmfw_pkg::ST_GRANTED, 1'b0, 4'd0, 8'd0}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd0,   1,   1'b1,
				'{rmfw_pkg::ST_OVERFLOW, 1'b0, 4'd0, 8'd255}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd15,  1,   1'b1,
				'{rmfw_pkg::ST_BLOCKED, 1'b0, 4'd0, 8'd255}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd15,  1,   1'b1,
				'{rmfw_pkg::ST_ALREADY_WAITING, 1'b0, 4'd0, 8'd255}},
			'{rmfw_pkg::CMD_RELEASE, 4'd15,  1,   1'b1,
				'{rmfw_pkg::ST_NOT_HOLDER, 1'b0, 4'd0, 8'd255}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd5,   1,   1'b1,
				'{rmfw_pkg::ST_BLOCKED, 1'b0, 4'd0, 8'd255}},
			'{rmfw_pkg::CMD_RELEASE, 4'd0,   254, 1'b0,
				'{rmfw_pkg::ST_GRANTED, 1'b0, 4'd0, 8'd0}},
			'{rmfw_pkg::CMD_RELEASE, 4'd0,   1,   1'b1,
				'{rmfw_pkg::ST_FREED, 1'b1, 4'd15, 8'd0}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd5,   1,   1'b1,
				'{rmfw_pkg::ST_ALREADY_WAITING, 1'b0, 4'd0, 8'd0}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd15,  1,   1'b1,
				'{rmfw_pkg::ST_GRANTED, 1'b0, 4'd0, 8'd1}},
			'{rmfw_pkg::CMD_RELEASE, 4'd15,  1,   1'b1,
				'{rmfw_pkg::ST_FREED, 1'b1, 4'd5, 8'd0}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd5,   1,   1'b1,
				'{rmfw_pkg::ST_GRANTED, 1'b0, 4'd0, 8'd1}},
			'{rmfw_pkg::CMD_RELEASE, 4'd5,   1,   1'b1,
				'{rmfw_pkg::ST_FREED, 1'b0, 4'd0, 8'd0}},
			'{rmfw_pkg::CMD_ACQUIRE, 4'd10,  1,   1'b1,
				'{rmfw_pkg::ST_GRANTED, 1'b0, 4'd0, 8'd1}},
			'{rmfw_pkg::CMD_RELEASE, 4'd10,  1,   1'b1,
				'{rmfw_pkg::ST_FREED, 1'b0, 4'd0, 8'd0}}
		};

		lock_held    = 1'b0;
		owner_tid    = '0;
		owner_depth  = '0;
		waiting_bits = '0;
		retry_tid    = -1;
		word_count   = 0;
		errors       = 0;

		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.cmd       <= rmfw_pkg::CMD_ACQUIRE;
		req_ch.thread_id <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed script
		foreach (script[r]) begin
			for (int k = 0; k < script[r].reps; k++) begin
				send_word(script[r].op, script[r].tid, script[r].typed, script[r].want);
				idle_sender(1'b0);
			end
		end
		idle_sender(1'b1);

		// random traffic, biased toward well-formed lock usage
		for (int i = 0; i < RANDOM_OPS; i++) begin
			roll = $urandom_range(99);
			tid  = TID_W'($urandom_range(THREADS - 1));
			op   = rmfw_pkg::CMD_ACQUIRE;
			if (roll < 30) begin
				op = rmfw_pkg::CMD_ACQUIRE;
			end else if (roll < 55) begin
				op = rmfw_pkg::CMD_RELEASE;
				if (lock_held)
					tid = owner_tid;
			end else if (roll < 68) begin
				if (lock_held)
					tid = owner_tid;
			end else if (roll < 80) begin
				// woken thread retries
				if (retry_tid >= 0)
					tid = TID_W'(retry_tid);
			end else if (roll < 90) begin
				op = rmfw_pkg::CMD_RELEASE;
			end
			send_word(op, tid, 1'b0, none);
			idle_sender(i == PAUSE_AT);
		end
		req_ch.valid <= 1'b0;

		// drain, then let the pipeline settle
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Response side: random back-pressure plus one long hold
	initial begin
		int gap;
		hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!hold_done && word_count >= HOLD_AT) begin
				hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(20, 1)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Compare each accepted response word with the oldest expectation
	always @(posedge clk) begin
		lock_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: response word with nothing expected (status %0d)",
					$time, rsp_ch.status);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, rsp_ch.status);
					errors++;
				end
				if (rsp_ch.wake_valid !== want.wake_valid) begin
					$display("%0t: wake_valid expected %0d, got %0d",
						$time, want.wake_valid, rsp_ch.wake_valid);
					errors++;
				end
				if (rsp_ch.wake_thread !== want.wake_thread) begin
					$display("%0t: wake_thread expected %0d, got %0d",
						$time, want.wake_thread, rsp_ch.wake_thread);
					errors++;
				end
				if (rsp_ch.hold_count !== want.hold_count) begin
					$display("%0t: hold_count expected %0d, got %0d",
						$time, want.hold_count, rsp_ch.hold_count);
					errors++;
				end
			end
		end
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
